// File: src/kdr_pkg.sv
// Shared types and constants for the multi-key debounce / repeat / long-press block.
// Holds the transaction payload structs, the per-key state entry and the sequencer states.
// No dependencies; every other file in src imports this package.
package kdr_pkg;

    localparam int NUM_KEYS        = 7;
    localparam int RESET_KEY_INDEX = 6;
    localparam int TIME_W          = 32;
    localparam int KEY_W           = $clog2(NUM_KEYS);
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;

    // Level of a key that is not pressed (inputs are active low)
    localparam logic KEY_RELEASED = 1'b1;

    typedef logic [TIME_W-1:0] tick_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_RESET_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE     = 3'd6;

    typedef enum logic [1:0] {
        EV_PRESS      = 2'd0,
        EV_HOLD       = 2'd1,
        EV_SYS_RESET  = 2'd2,
        EV_REPEAT     = 2'd3
    } ev_kind_t;

    typedef struct packed {
        tick_t               scan_time;
        logic [NUM_KEYS-1:0] raw_levels;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        ev_kind_t         event_kind;
        tick_t            event_time;
        logic             last_of_scan;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0]    scan_interval;
        logic [CFG_W-1:0]    debounce_time;
        logic [CFG_W-1:0]    repeat_delay;
        logic [CFG_W-1:0]    repeat_interval;
        logic [CFG_W-1:0]    hold_time;
        logic [CFG_W-1:0]    system_reset_time;
        logic [NUM_KEYS-1:0] repeat_enable_mask;
    } cfg_t;

    // Per-key state kept in the key memory
    typedef struct packed {
        logic  raw_level;
        logic  stable_level;
        tick_t raw_change_stamp;
        tick_t press_stamp;
        tick_t repeat_deadline;
        logic  hold_done;
        logic  system_reset_done;
    } key_entry_t;

    localparam key_entry_t KEY_ENTRY_RESET = '{
        raw_level:         KEY_RELEASED,
        stable_level:      KEY_RELEASED,
        raw_change_stamp:  '0,
        press_stamp:       '0,
        repeat_deadline:   '0,
        hold_done:         1'b0,
        system_reset_done: 1'b0
    };

    // Events raised by one key visit, in emission order press, long, sys, repeat
    typedef struct packed {
        logic press;
        logic hold_evt;
        logic sys_reset;
        logic auto_rep;
    } ev_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_EMIT,
        ST_FLUSH
    } seq_state_t;

endpackage

// File: src/kdr_cfg_regs.sv
// Configuration register bank: seven write-only registers with their reset values.
// Depends on kdr_pkg for cfg_t and the register index constants.
module kdr_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [kdr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [kdr_pkg::CFG_W-1:0] cfg_wdata,
    output kdr_pkg::cfg_t             cfg
);
    import kdr_pkg::*;

    cfg_t cfg_reg;

    // Load defaults at reset, then take single-register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_interval      <= 16'd10;
            cfg_reg.debounce_time      <= 16'd20;
            cfg_reg.repeat_delay       <= 16'd500;
            cfg_reg.repeat_interval    <= 16'd100;
            cfg_reg.hold_time          <= 16'd1000;
            cfg_reg.system_reset_time  <= 16'd5000;
            cfg_reg.repeat_enable_mask <= 7'd15;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SCAN_INTERVAL:     cfg_reg.scan_interval     <= cfg_wdata;
                CFG_DEBOUNCE_TIME:     cfg_reg.debounce_time     <= cfg_wdata;
                CFG_REPEAT_DELAY:      cfg_reg.repeat_delay      <= cfg_wdata;
                CFG_REPEAT_INTERVAL:   cfg_reg.repeat_interval   <= cfg_wdata;
                CFG_HOLD_TIME:         cfg_reg.hold_time         <= cfg_wdata;
                CFG_SYSTEM_RESET_TIME: cfg_reg.system_reset_time <= cfg_wdata;
                CFG_REPEAT_ENABLE:
                    cfg_reg.repeat_enable_mask <= cfg_wdata[NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/kdr_key_mem.sv
// Per-key state memory: one entry per key, one write and one registered read per cycle.
// Valid bits make never-written entries read as the reset entry. Depends on kdr_pkg.
module kdr_key_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [kdr_pkg::KEY_W-1:0] rd_addr,
    output kdr_pkg::key_entry_t       rd_entry,
    input  logic                      wr_en,
    input  logic [kdr_pkg::KEY_W-1:0] wr_addr,
    input  kdr_pkg::key_entry_t       wr_entry
);
    import kdr_pkg::*;

    key_entry_t          mem [NUM_KEYS];
    key_entry_t          rd_data_reg;
    logic [NUM_KEYS-1:0] valid_reg;
    logic                rd_valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track which entries have been written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : KEY_ENTRY_RESET;

endmodule

// File: src/kdr_key_eval.sv
// Per-key update: debounce, press detection, long-press, system-reset and auto-repeat.
// Pure combinational read-modify step on one memory entry. Depends on kdr_pkg.
module kdr_key_eval (
    input  logic [kdr_pkg::KEY_W-1:0] key,
    input  kdr_pkg::tick_t            now,
    input  logic                      raw,
    input  kdr_pkg::cfg_t             cfg,
    input  kdr_pkg::key_entry_t       entry,
    output kdr_pkg::key_entry_t       entry_next,
    output kdr_pkg::ev_flags_t        ev
);
    import kdr_pkg::*;

    tick_t raw_stamp;
    tick_t since_raw;
    tick_t since_press;
    tick_t past_deadline;
    logic  is_reset_key;
    logic  rep_en;
    logic  debounced;

    assign raw_stamp     = (raw != entry.raw_level) ? now : entry.raw_change_stamp;
    assign since_raw     = now - raw_stamp;
    assign since_press   = now - entry.press_stamp;
    assign past_deadline = now - entry.repeat_deadline;
    assign is_reset_key  = (key == KEY_W'(RESET_KEY_INDEX));
    assign rep_en        = cfg.repeat_enable_mask[key];
    assign debounced     = (raw != entry.stable_level) &&
                           (since_raw >= tick_t'(cfg.debounce_time));

    always_comb begin
        entry_next                  = entry;
        entry_next.raw_level        = raw;
        entry_next.raw_change_stamp = raw_stamp;
        ev                          = '0;

        if (debounced) begin
            // Take the new stable level; a press arms timers and clears flags
            entry_next.stable_level = raw;
            if (raw != KEY_RELEASED) begin
                entry_next.press_stamp       = now;
                entry_next.repeat_deadline   = now + tick_t'(cfg.repeat_delay);
                entry_next.hold_done         = 1'b0;
                entry_next.system_reset_done = 1'b0;
                ev.press                     = 1'b1;
            end
        end else if (entry.stable_level != KEY_RELEASED) begin
            // Held key: check hold timers and the repeat deadline
            if (is_reset_key && !entry.hold_done &&
                since_press >= tick_t'(cfg.hold_time)) begin
                entry_next.hold_done = 1'b1;
                ev.hold_evt          = 1'b1;
            end
            if (is_reset_key && !entry.system_reset_done &&
                since_press >= tick_t'(cfg.system_reset_time)) begin
                entry_next.system_reset_done = 1'b1;
                ev.sys_reset                 = 1'b1;
            end
            if (rep_en && !past_deadline[TIME_W-1]) begin
                entry_next.repeat_deadline = now + tick_t'(cfg.repeat_interval);
                ev.auto_rep                = 1'b1;
            end
        end
    end

endmodule

// File: src/multi_key_debounce_repeat_longpress.sv
// Multi-key debouncer with press, auto-repeat, long-press and system-reset events.
// Top level: scan sequencer and output staging. Depends on kdr_pkg, kdr_cfg_regs,
// kdr_key_mem and kdr_key_eval.
// Usage:
//   s_* carries one poll per transaction: a millisecond tick and seven active-low
//   key levels. m_* carries one event per transaction; last_of_scan marks the
//   final event of a scan. A poll closer than scan_interval to the previous
//   accepted scan produces nothing. cfg_we/cfg_addr/cfg_wdata write the seven
//   configuration registers and must only be used while the block is idle.
//   Steps: a poll is first checked against the scan interval, then the keys are
//   visited in turn (a read of the per-key state memory overlapped with the
//   write-back of the previous key), with one more step per event raised and a
//   final step to close the scan.
//   Each event is held back one step so last_of_scan is known; an event reaches
//   m_* only when the next event or the close of the scan pushes it out.
//   A full output register lets the sequencer run on; it only waits when a
//   further event must be handed over while m_ready stays low.
//   Reset (aresetn low, synchronous) restores register defaults, marks all keys
//   released with zeroed timers and drops any event not yet delivered.
module multi_key_debounce_repeat_longpress (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kdr_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kdr_pkg::out_item_t            m_data,
    input  logic                          cfg_we,
    input  logic [kdr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [kdr_pkg::CFG_W-1:0]     cfg_wdata
);
    import kdr_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    tick_t               now_reg;
    logic [NUM_KEYS-1:0] levels_reg;
    tick_t               last_scan_reg;
    ev_flags_t           ev_reg;
    logic                pend_valid_reg;
    out_item_t           pend_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    cfg_t       cfg;
    key_entry_t rd_entry;
    key_entry_t entry_next;
    ev_flags_t  ev_now;
    ev_flags_t  ev_rest;
    ev_kind_t   ev_kind_sel;
    out_item_t  push_item;

    logic scan_due;
    logic key_last;
    logic out_free;
    logic emit_go;
    logic flush_go;
    logic push_out;
    logic rd_en;
    logic wr_en;

    kdr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kdr_key_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (key_next),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (key_reg),
        .wr_entry (entry_next)
    );

    kdr_key_eval u_eval (
        .key        (key_reg),
        .now        (now_reg),
        .raw        (levels_reg[key_reg]),
        .cfg        (cfg),
        .entry      (rd_entry),
        .entry_next (entry_next),
        .ev         (ev_now)
    );

    // Status terms
    assign scan_due = (now_reg - last_scan_reg) >= tick_t'(cfg.scan_interval);
    assign key_last = (key_reg == KEY_W'(NUM_KEYS - 1));
    assign out_free = !m_valid_reg || m_ready;

    // Pick the next pending event of the current key, in emission order
    always_comb begin
        ev_rest     = ev_reg;
        ev_kind_sel = EV_REPEAT;
        if (ev_reg.press) begin
            ev_kind_sel   = EV_PRESS;
            ev_rest.press = 1'b0;
        end else if (ev_reg.hold_evt) begin
            ev_kind_sel      = EV_HOLD;
            ev_rest.hold_evt = 1'b0;
        end else if (ev_reg.sys_reset) begin
            ev_kind_sel       = EV_SYS_RESET;
            ev_rest.sys_reset = 1'b0;
        end else begin
            ev_rest.auto_rep = 1'b0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = scan_due ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                if (|ev_now)       state_next = ST_EMIT;
                else if (key_last) state_next = ST_FLUSH;
            end
            ST_EMIT: begin
                if (emit_go && !(|ev_rest)) state_next = key_last ? ST_FLUSH : ST_EVAL;
            end
            ST_FLUSH: begin
                if (flush_go || !pend_valid_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        emit_go  = (state_reg == ST_EMIT) && (!pend_valid_reg || out_free);
        flush_go = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;
        push_out = (emit_go && pend_valid_reg) || flush_go;
        wr_en    = (state_reg == ST_EVAL);
        rd_en    = (state_next == ST_EVAL);
        key_next = key_reg;
        case (state_reg)
            ST_CHECK: key_next = '0;
            ST_EVAL: begin
                if (!(|ev_now) && !key_last) key_next = key_reg + 1'b1;
            end
            ST_EMIT: begin
                if (emit_go && !(|ev_rest) && !key_last) key_next = key_reg + 1'b1;
            end
            default: key_next = key_reg;
        endcase
    end

    // Mark the held-back event as last only when the scan closes
    always_comb begin
        push_item              = pend_reg;
        push_item.last_of_scan = (state_reg == ST_FLUSH);
    end

    // Sequencer and handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            key_reg        <= '0;
            last_scan_reg  <= '0;
            ev_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            key_reg   <= key_next;
            if (state_reg == ST_CHECK && scan_due) begin
                last_scan_reg <= now_reg;
            end
            if (state_reg == ST_EVAL) begin
                ev_reg <= ev_now;
            end else if (emit_go) begin
                ev_reg <= ev_rest;
            end
            if (emit_go) begin
                pend_valid_reg <= 1'b1;
            end else if (flush_go) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the poll, stage the held-back event, load the output
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg    <= s_data.scan_time;
            levels_reg <= s_data.raw_levels;
        end
        if (emit_go) begin
            pend_reg.key_index    <= key_reg;
            pend_reg.event_kind   <= ev_kind_sel;
            pend_reg.event_time   <= now_reg;
            pend_reg.last_of_scan <= 1'b0;
        end
        if (push_out) begin
            m_data_reg <= push_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: verif/testbench.sv
// Testbench for multi_key_debounce_repeat_longpress: directed and random polls, with a
// scoreboard class that predicts every key event and checks it against the result channel.
// Depends on kdr_pkg and the block's RTL in src.
`timescale 1ns / 1ps

module testbench;
    import kdr_pkg::*;

    // Register index past the last register; writes to it must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    // Predicts the events of each accepted poll and checks delivered events in order
    class key_event_board;
        logic [CFG_W-1:0]    scan_interval;
        logic [CFG_W-1:0]    debounce_time;
        logic [CFG_W-1:0]    repeat_delay;
        logic [CFG_W-1:0]    repeat_interval;
        logic [CFG_W-1:0]    hold_time;
        logic [CFG_W-1:0]    system_reset_time;
        logic [NUM_KEYS-1:0] repeat_mask;

        tick_t last_scan;
        logic  raw_lvl      [NUM_KEYS];
        logic  stable_lvl   [NUM_KEYS];
        tick_t change_stamp [NUM_KEYS];
        tick_t press_stamp  [NUM_KEYS];
        tick_t deadline     [NUM_KEYS];
        bit    long_done    [NUM_KEYS];
        bit    sys_done     [NUM_KEYS];

        out_item_t due_events[$];
        int        mismatches;
        int        events_seen;

        function new();
            scan_interval     = 16'd10;
            debounce_time     = 16'd20;
            repeat_delay      = 16'd500;
            repeat_interval   = 16'd100;
            hold_time         = 16'd1000;
            system_reset_time = 16'd5000;
            repeat_mask       = 7'd15;
            last_scan         = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                raw_lvl[k]      = KEY_RELEASED;
                stable_lvl[k]   = KEY_RELEASED;
                change_stamp[k] = '0;
                press_stamp[k]  = '0;
                deadline[k]     = '0;
                long_done[k]    = 1'b0;
                sys_done[k]     = 1'b0;
            end
            mismatches  = 0;
            events_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SCAN_INTERVAL:     scan_interval     = val;
                CFG_DEBOUNCE_TIME:     debounce_time     = val;
                CFG_REPEAT_DELAY:      repeat_delay      = val;
                CFG_REPEAT_INTERVAL:   repeat_interval   = val;
                CFG_HOLD_TIME:         hold_time         = val;
                CFG_SYSTEM_RESET_TIME: system_reset_time = val;
                CFG_REPEAT_ENABLE:     repeat_mask       = val[NUM_KEYS-1:0];
                default: ;
            endcase
        endfunction

        function out_item_t make_event(int k, ev_kind_t kind, tick_t now);
            out_item_t e;
            e.key_index    = KEY_W'(k);
            e.event_kind   = kind;
            e.event_time   = now;
            e.last_of_scan = 1'b0;
            return e;
        endfunction

        // Run one poll through the key state; returns 1 when the scan is accepted
        function bit note_poll(in_item_t poll);
            out_item_t batch[$];
            tick_t     now;
            tick_t     dt;
            logic      raw;
            now = poll.scan_time;
            dt  = now - last_scan;
            if (dt < scan_interval) return 1'b0;
            last_scan = now;
            for (int k = 0; k < NUM_KEYS; k++) begin
                raw = poll.raw_levels[k];
                if (raw != raw_lvl[k]) begin
                    raw_lvl[k]      = raw;
                    change_stamp[k] = now;
                end
                // Debounced change: a press raises its event, a release is silent
                dt = now - change_stamp[k];
                if (raw != stable_lvl[k] && dt >= debounce_time) begin
                    stable_lvl[k] = raw;
                    if (raw != KEY_RELEASED) begin
                        press_stamp[k] = now;
                        deadline[k]    = now + repeat_delay;
                        long_done[k]   = 1'b0;
                        sys_done[k]    = 1'b0;
                        batch.push_back(make_event(k, EV_PRESS, now));
                    end
                    continue;
                end
                if (stable_lvl[k] == KEY_RELEASED) continue;
                // Held key: long press and system reset on the reset key, then repeat
                dt = now - press_stamp[k];
                if (k == RESET_KEY_INDEX && !long_done[k] && dt >= hold_time) begin
                    long_done[k] = 1'b1;
                    batch.push_back(make_event(k, EV_HOLD, now));
                end
                if (k == RESET_KEY_INDEX && !sys_done[k] && dt >= system_reset_time) begin
                    sys_done[k] = 1'b1;
                    batch.push_back(make_event(k, EV_SYS_RESET, now));
                end
                dt = now - deadline[k];
                if (repeat_mask[k] && !dt[TIME_W-1]) begin
                    deadline[k] = now + repeat_interval;
                    batch.push_back(make_event(k, EV_REPEAT, now));
                end
            end
            if (batch.size() > 0) batch[batch.size()-1].last_of_scan = 1'b1;
            foreach (batch[i]) due_events.push_back(batch[i]);
            return 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30) $display("ERROR @%0t: %s", $time, msg);
        endtask

        // Compare one delivered event with the oldest predicted one
        task check_event(out_item_t got);
            out_item_t want;
            events_seen++;
            if (due_events.size() == 0) begin
                report($sformatf("unexpected event key %0d kind %0d time %h",
                                 got.key_index, got.event_kind, got.event_time));
                return;
            end
            want = due_events.pop_front();
            if (got.key_index !== want.key_index)
                report($sformatf("event %0d: key_index %0d, want %0d",
                                 events_seen, got.key_index, want.key_index));
            if (got.event_kind !== want.event_kind)
                report($sformatf("event %0d: event_kind %0d, want %0d",
                                 events_seen, got.event_kind, want.event_kind));
            if (got.event_time !== want.event_time)
                report($sformatf("event %0d: event_time %h, want %h",
                                 events_seen, got.event_time, want.event_time));
            if (got.last_of_scan !== want.last_of_scan)
                report($sformatf("event %0d: last_of_scan %0b, want %0b",
                                 events_seen, got.last_of_scan, want.last_of_scan));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    key_event_board      board = new();
    tick_t               cur_tick;
    logic [NUM_KEYS-1:0] cur_levels;
    bit                  send_calm;
    bit                  recv_calm;
    bit                  held_off;
    bit                  hold_armed;

    multi_key_debounce_repeat_longpress DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one poll after a random gap and hold it until the block takes it
    task automatic send_poll(input tick_t t, input logic [NUM_KEYS-1:0] lvl, output bit took);
        in_item_t item;
        int       gap;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        gap             = send_calm ? 0 : $urandom_range(0, 3);
        item.scan_time  = t;
        item.raw_levels = lvl;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        took = board.note_poll(item);
    endtask

    task automatic poll(input tick_t t, input logic [NUM_KEYS-1:0] lvl);
        bit took;
        send_poll(t, lvl, took);
    endtask

    // Drop valid, wait for every predicted event, then let the last scan finish
    task automatic settle();
        s_valid <= 1'b0;
        while (board.due_events.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] si, input logic [CFG_W-1:0] db,
                                input logic [CFG_W-1:0] rd, input logic [CFG_W-1:0] ri,
                                input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] sr,
                                input logic [CFG_W-1:0] mask);
        write_reg(CFG_SCAN_INTERVAL, si);
        write_reg(CFG_DEBOUNCE_TIME, db);
        write_reg(CFG_REPEAT_DELAY, rd);
        write_reg(CFG_REPEAT_INTERVAL, ri);
        write_reg(CFG_HOLD_TIME, lp);
        write_reg(CFG_SYSTEM_RESET_TIME, sr);
        write_reg(CFG_REPEAT_ENABLE, mask);
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Mostly steady ticks a little past the scan interval with keys toggling now and
    // then; a few early polls, jumps anywhere in time and scrambled key levels
    task automatic random_phase(input int target);
        int          accepted;
        int          r;
        int          idx;
        int unsigned si;
        bit          took;
        accepted = 0;
        while (accepted < target) begin
            si = board.scan_interval;
            r  = $urandom_range(0, 99);
            if (r < 8 && si > 0)
                cur_tick = cur_tick + $urandom_range(0, si - 1);
            else if (r < 13)
                cur_tick = $urandom;
            else
                cur_tick = cur_tick + si + $urandom_range(0, si / 2 + 2);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                cur_levels = NUM_KEYS'($urandom);
            end else if (r < 25) begin
                idx             = $urandom_range(0, NUM_KEYS - 1);
                cur_levels[idx] = ~cur_levels[idx];
            end
            send_poll(cur_tick, cur_levels, took);
            if (took) accepted++;
        end
    endtask

    // Result side: random ready gaps, one long hold-off to back the block up
    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (!held_off && hold_armed) begin
                held_off = 1'b1;
                gap      = 400;
            end else begin
                if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
                gap = recv_calm ? 0 : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_event(m_data);
        end
    end

    initial begin
        int waited;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_SCAN_INTERVAL;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Default registers: early tick, debounce, press, repeat, long press,
        // system reset, then a silent release
        poll(32'd5, 7'h7F);
        poll(32'd10, 7'h00);
        poll(32'd25, 7'h00);
        poll(32'd30, 7'h00);
        poll(32'd35, 7'h00);
        poll(32'd535, 7'h00);
        poll(32'd1035, 7'h00);
        poll(32'd5035, 7'h00);
        poll(32'd5045, 7'h7F);
        poll(32'd5070, 7'h7F);
        settle();

        // Zero timers but the repeat interval, every key repeat-enabled: reset key raises
        // long press, system reset and repeat in one scan; ticks wrap, deadlines cross the sign bit
        program_regs(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        poll(32'hFFFF_FFF0, 7'h3F);
        poll(32'hFFFF_FFFF, 7'h3F);
        poll(32'h0000_0005, 7'h00);
        poll(32'h8000_0000, 7'h00);
        poll(32'h8000_0000, 7'h55);
        poll(32'h8000_0001, 7'h2A);
        settle();

        cur_tick   = 32'h8000_0001;
        cur_levels = 7'h7F;

        // Stall the result side once while polls keep coming
        hold_armed = 1'b1;
        program_regs(16'd2, 16'd4, 16'd10, 16'd3, 16'd20, 16'd40, 16'($urandom_range(0, 127)));
        random_phase(62);
        settle();

        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0 | 16'h7F);
        random_phase(62);
        settle();

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(62);
        settle();

        program_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 50)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 60)), 16'($urandom_range(0, 120)),
                     16'($urandom));
        random_phase(62);

        // Drain with a bound, then give stray events time to show up
        s_valid <= 1'b0;
        waited = 0;
        while (board.due_events.size() > 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (board.due_events.size() != 0)
            board.report($sformatf("%0d predicted events never arrived",
                                   board.due_events.size()));
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/kdr_pkg.sv
src/kdr_cfg_regs.sv
src/kdr_key_mem.sv
src/kdr_key_eval.sv
src/multi_key_debounce_repeat_longpress.sv
verif/testbench.sv
